### sv/sap_pkg.sv
// ----------------------------------------------------------------------------
// sap_pkg
// Shared constants, codes and controller/datapath bundles of the shelf atlas
// packer.
// ----------------------------------------------------------------------------
`default_nettype none

package sap_pkg;

  // Parameter defaults
  localparam int unsigned INITIAL_ATLAS_LOG_DEF = 8;
  localparam int unsigned MAX_ATLAS_LOG_DEF     = 12;
  localparam int unsigned MAX_SHELVES_DEF       = 64;

  // Fixed field widths
  localparam int unsigned DIM_W   = 10;  // glyph width, height, shelf height
  localparam int unsigned COORD_W = 12;  // rect left, bottom, right
  localparam int unsigned TOP_W   = 13;  // rect top
  localparam int unsigned LOG_W   = 4;   // atlas size log
  localparam int unsigned DBL_W   = 3;   // reported doublings
  localparam int unsigned DBLC_W  = 4;   // internal doubling counter
  localparam int unsigned STAT_W  = 2;   // status

  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 64;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_PLACED     = 2'd0,
    ST_SHELF_FULL = 2'd1,
    ST_ATLAS_MAX  = 2'd2
  } status_e;

  // Controller states
  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic    start;       // load request, open a fresh search
    logic    scan;        // advance the shelf scan one entry
    logic    commit_old;  // place on the shelf that hit
    logic    commit_new;  // open a new shelf and place there
    logic    fail;        // report failure, keep state
    logic    grow;        // double the trial atlas and rescan
    status_e fail_code;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic hit;        // shelf in check stage takes the glyph
    logic scan_done;  // every shelf checked, nothing in flight
    logic fits;       // a new shelf fits under the trial side
    logic full;       // shelf table is full
    logic at_max;     // trial atlas already at maximum size
    logic out_free;   // output register can take a result
  } dp_status_t;

endpackage

`default_nettype wire

### sv/sap_ctrl.sv
// ----------------------------------------------------------------------------
// sap_ctrl
// Controller of the shelf atlas packer: accepts a request, steers the shelf
// scan and decides between placing, opening a shelf, doubling or failing.
// ----------------------------------------------------------------------------
`default_nettype none

module sap_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               req_valid_i,
  output      logic               req_ready_o,
  input  wire sap_pkg::dp_status_t stat_i,
  output      sap_pkg::cmd_t      cmd_o
);

  sap_pkg::state_e state_q, state_d;

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sap_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sap_pkg::S_IDLE: begin
        if (req_valid_i) begin
          state_d = sap_pkg::S_SCAN;
        end
      end
      sap_pkg::S_SCAN: begin
        if (stat_i.hit) begin
          if (stat_i.out_free) state_d = sap_pkg::S_IDLE;
        end else if (stat_i.scan_done) begin
          if (stat_i.fits || stat_i.at_max) begin
            if (stat_i.out_free) state_d = sap_pkg::S_IDLE;
          end
        end
      end
      default: state_d = sap_pkg::S_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd_o           = '0;
    cmd_o.fail_code = sap_pkg::ST_PLACED;
    req_ready_o     = 1'b0;
    unique case (state_q)
      sap_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.start = req_valid_i;
      end
      sap_pkg::S_SCAN: begin
        if (stat_i.hit) begin
          cmd_o.commit_old = stat_i.out_free;
        end else if (stat_i.scan_done) begin
          if (stat_i.fits && !stat_i.full) begin
            cmd_o.commit_new = stat_i.out_free;
          end else if (stat_i.fits) begin
            cmd_o.fail      = stat_i.out_free;
            cmd_o.fail_code = sap_pkg::ST_SHELF_FULL;
          end else if (stat_i.at_max) begin
            cmd_o.fail      = stat_i.out_free;
            cmd_o.fail_code = sap_pkg::ST_ATLAS_MAX;
          end else begin
            cmd_o.grow = 1'b1;
          end
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
      default: begin
        req_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### sv/sap_dp.sv
// ----------------------------------------------------------------------------
// sap_dp
// Datapath of the shelf atlas packer: shelf table memory, pipelined first-fit
// scan, atlas and shelf bookkeeping, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sap_dp #(
  parameter int unsigned INITIAL_ATLAS_LOG = sap_pkg::INITIAL_ATLAS_LOG_DEF,
  parameter int unsigned MAX_ATLAS_LOG     = sap_pkg::MAX_ATLAS_LOG_DEF,
  parameter int unsigned MAX_SHELVES       = sap_pkg::MAX_SHELVES_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [sap_pkg::DIM_W-1:0]   glyph_width_i,
  input  wire logic [sap_pkg::DIM_W-1:0]   glyph_height_i,
  input  wire logic [sap_pkg::DIM_W-1:0]   shelf_height_i,
  input  wire sap_pkg::cmd_t               cmd_i,
  output      sap_pkg::dp_status_t         stat_o,
  input  wire logic                        out_ready_i,
  output      logic                        out_valid_o,
  output      logic [sap_pkg::COORD_W-1:0] rect_left_o,
  output      logic [sap_pkg::COORD_W-1:0] rect_bottom_o,
  output      logic [sap_pkg::COORD_W-1:0] rect_right_o,
  output      logic [sap_pkg::TOP_W-1:0]   rect_top_o,
  output      logic [sap_pkg::LOG_W-1:0]   atlas_size_log_o,
  output      logic [sap_pkg::DBL_W-1:0]   doublings_o,
  output      sap_pkg::status_e            status_o
);

  // Largest atlas log the packer can hold, also when it starts above the maximum
  localparam int unsigned LOG_TOP =
    (INITIAL_ATLAS_LOG > MAX_ATLAS_LOG) ? INITIAL_ATLAS_LOG : MAX_ATLAS_LOG;
  localparam int unsigned IDX_W  = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_SHELVES + 1);
  localparam int unsigned SUM_W  =
    ((LOG_TOP > sap_pkg::DIM_W) ? LOG_TOP : sap_pkg::DIM_W) + 1;
  localparam int unsigned LEN_W  = SUM_W - 1;
  localparam int unsigned POS_W  = LOG_TOP + 1;
  localparam int unsigned WIDE_W = (SUM_W > sap_pkg::TOP_W) ? SUM_W : sap_pkg::TOP_W;
  localparam int unsigned LW     = sap_pkg::LOG_W;

  // Shelf table
  logic [sap_pkg::DIM_W-1:0] mem_h_q   [MAX_SHELVES];
  logic [POS_W-1:0]          mem_pos_q [MAX_SHELVES];
  logic [LEN_W-1:0]          mem_len_q [MAX_SHELVES];

  // Request
  logic [sap_pkg::DIM_W-1:0] width_q, height_q, sh_q;

  // Search state
  logic [LW-1:0]              lg_q, lg_d;
  logic [sap_pkg::DBLC_W-1:0] dbl_q, dbl_d;
  logic [CNT_W-1:0]           idx_q, idx_d;
  logic                       chk_vld_q, chk_vld_d;
  logic [IDX_W-1:0]           chk_idx_q;
  logic [sap_pkg::DIM_W-1:0]  rd_h_q;
  logic [POS_W-1:0]           rd_pos_q;
  logic [LEN_W-1:0]           rd_len_q;

  // Persistent packer state
  logic [LW-1:0]    atlas_log_q, atlas_log_d;
  logic [CNT_W-1:0] shelf_count_q, shelf_count_d;
  logic [POS_W-1:0] next_pos_q, next_pos_d;

  // Output register
  logic                        out_vld_q, out_vld_d;
  logic [sap_pkg::COORD_W-1:0] o_left_q, o_bottom_q, o_right_q;
  logic [sap_pkg::TOP_W-1:0]   o_top_q;
  logic [LW-1:0]               o_log_q;
  logic [sap_pkg::DBL_W-1:0]   o_dbl_q;
  sap_pkg::status_e            o_stat_q;

  logic [SUM_W-1:0]  side, len_sum, new_end;
  logic              more, rd_en, commit;
  logic [LEN_W-1:0]  base_len;
  logic [POS_W-1:0]  base_pos;
  logic [WIDE_W-1:0] right_w, top_w;

  // Compare the checked shelf and the new-shelf option against the trial side
  always_comb begin
    side    = SUM_W'(1) << lg_q;
    len_sum = SUM_W'(rd_len_q) + SUM_W'(width_q);
    new_end = SUM_W'(next_pos_q) + SUM_W'(sh_q);
    more    = idx_q < shelf_count_q;
    rd_en   = cmd_i.scan && more;
    commit  = cmd_i.commit_old || cmd_i.commit_new || cmd_i.fail;

    stat_o.hit       = chk_vld_q && (rd_h_q >= sh_q) && (len_sum < side);
    stat_o.scan_done = !chk_vld_q && !more;
    stat_o.fits      = new_end <= side;
    stat_o.full      = shelf_count_q == CNT_W'(MAX_SHELVES);
    stat_o.at_max    = lg_q >= LW'(MAX_ATLAS_LOG);
    stat_o.out_free  = !out_vld_q || out_ready_i;
  end

  // Select the placed rectangle
  always_comb begin
    base_len = cmd_i.commit_new ? '0 : rd_len_q;
    base_pos = cmd_i.commit_new ? next_pos_q : rd_pos_q;
    right_w  = WIDE_W'(base_len) + WIDE_W'(width_q);
    top_w    = WIDE_W'(base_pos) + WIDE_W'(height_q);
  end

  // Next values of the search and packer state
  always_comb begin
    lg_d          = lg_q;
    dbl_d         = dbl_q;
    idx_d         = idx_q;
    chk_vld_d     = chk_vld_q;
    atlas_log_d   = atlas_log_q;
    shelf_count_d = shelf_count_q;
    next_pos_d    = next_pos_q;
    out_vld_d     = out_vld_q && !out_ready_i;

    if (cmd_i.start) begin
      lg_d      = atlas_log_q;
      dbl_d     = '0;
      idx_d     = '0;
      chk_vld_d = 1'b0;
    end
    if (cmd_i.grow) begin
      lg_d      = lg_q + LW'(1);
      dbl_d     = dbl_q + sap_pkg::DBLC_W'(1);
      idx_d     = '0;
      chk_vld_d = 1'b0;
    end
    if (cmd_i.scan) begin
      chk_vld_d = more;
      if (more) idx_d = idx_q + CNT_W'(1);
    end
    if (cmd_i.commit_old || cmd_i.commit_new) begin
      atlas_log_d = lg_q;
      chk_vld_d   = 1'b0;
    end
    if (cmd_i.commit_new) begin
      shelf_count_d = shelf_count_q + CNT_W'(1);
      next_pos_d    = POS_W'(new_end);
    end
    if (commit) out_vld_d = 1'b1;
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lg_q          <= LW'(INITIAL_ATLAS_LOG);
      dbl_q         <= '0;
      idx_q         <= '0;
      chk_vld_q     <= 1'b0;
      atlas_log_q   <= LW'(INITIAL_ATLAS_LOG);
      shelf_count_q <= '0;
      next_pos_q    <= '0;
      out_vld_q     <= 1'b0;
    end else begin
      lg_q          <= lg_d;
      dbl_q         <= dbl_d;
      idx_q         <= idx_d;
      chk_vld_q     <= chk_vld_d;
      atlas_log_q   <= atlas_log_d;
      shelf_count_q <= shelf_count_d;
      next_pos_q    <= next_pos_d;
      out_vld_q     <= out_vld_d;
    end
  end

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      width_q  <= glyph_width_i;
      height_q <= glyph_height_i;
      sh_q     <= shelf_height_i;
    end
  end

  // Shelf table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit_new) begin
      mem_h_q[shelf_count_q[IDX_W-1:0]]   <= sh_q;
      mem_pos_q[shelf_count_q[IDX_W-1:0]] <= next_pos_q;
      mem_len_q[shelf_count_q[IDX_W-1:0]] <= LEN_W'(width_q);
    end else if (cmd_i.commit_old) begin
      mem_len_q[chk_idx_q] <= LEN_W'(len_sum);
    end
    if (rd_en) begin
      rd_h_q    <= mem_h_q[idx_q[IDX_W-1:0]];
      rd_pos_q  <= mem_pos_q[idx_q[IDX_W-1:0]];
      rd_len_q  <= mem_len_q[idx_q[IDX_W-1:0]];
      chk_idx_q <= idx_q[IDX_W-1:0];
    end
  end

  // Load the output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.fail) begin
      o_left_q   <= '0;
      o_bottom_q <= '0;
      o_right_q  <= '0;
      o_top_q    <= '0;
      o_log_q    <= atlas_log_q;
      o_dbl_q    <= '0;
      o_stat_q   <= cmd_i.fail_code;
    end else if (cmd_i.commit_old || cmd_i.commit_new) begin
      o_left_q   <= sap_pkg::COORD_W'(WIDE_W'(base_len));
      o_bottom_q <= sap_pkg::COORD_W'(WIDE_W'(base_pos));
      o_right_q  <= right_w[sap_pkg::COORD_W-1:0];
      o_top_q    <= top_w[sap_pkg::TOP_W-1:0];
      o_log_q    <= lg_q;
      o_dbl_q    <= dbl_q[sap_pkg::DBL_W-1:0];
      o_stat_q   <= sap_pkg::ST_PLACED;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign rect_left_o      = o_left_q;
  assign rect_bottom_o    = o_bottom_q;
  assign rect_right_o     = o_right_q;
  assign rect_top_o       = o_top_q;
  assign atlas_size_log_o = o_log_q;
  assign doublings_o      = o_dbl_q;
  assign status_o         = o_stat_q;

endmodule

`default_nettype wire

### sv/shelf_atlas_packer.sv
// Shelf atlas packer: first-fit placement of glyph rectangles on shelves of a
// square atlas that doubles its side when nothing fits.
// Input stream: one transaction per glyph request (width, height, needed
// shelf height). Output stream: one transaction per request with the pixel
// rectangle, the atlas size log, the doublings caused and a status (placed,
// shelf table full, atlas at maximum size). On failure nothing is placed.
// One request is worked on at a time; s_axis_tready is high only while the
// packer is idle, also while an earlier result still waits in the output
// register. Each scan pass reads the shelves in order; when no shelf takes
// the glyph and no new shelf fits, the trial atlas doubles and a new pass
// starts, so a search runs one pass plus one per doubling. The controller
// returns to idle on the edge that loads the result. The scan reads the
// shelf table one entry per cycle through its single registered read port,
// so the shelf count sets the request rate.
// Reset empties the shelf table (count and next position zero) and sets the
// atlas back to its initial size; no clearing pass is run.
// When the receiver stalls, the result is held in the output register and a
// finished search waits until that register is free before it commits.
// ----------------------------------------------------------------------------
// shelf_atlas_packer
// Top level: stream ports, controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module shelf_atlas_packer #(
  parameter int unsigned INITIAL_ATLAS_LOG = sap_pkg::INITIAL_ATLAS_LOG_DEF,
  parameter int unsigned MAX_ATLAS_LOG     = sap_pkg::MAX_ATLAS_LOG_DEF,
  parameter int unsigned MAX_SHELVES       = sap_pkg::MAX_SHELVES_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output      logic                            s_axis_tready,
  // glyph_width [9:0], glyph_height [19:10], shelf_height [29:20], zero [31:30]
  input  wire logic [sap_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // rect_left [11:0], rect_bottom [23:12], rect_right [35:24], rect_top [48:36],
  // atlas_size_log [52:49], doublings [55:53], status [57:56], zero [63:58]
  output      logic [sap_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  sap_pkg::cmd_t       cmd;
  sap_pkg::dp_status_t dp_stat;

  logic [sap_pkg::COORD_W-1:0] rect_left, rect_bottom, rect_right;
  logic [sap_pkg::TOP_W-1:0]   rect_top;
  logic [sap_pkg::LOG_W-1:0]   atlas_size_log;
  logic [sap_pkg::DBL_W-1:0]   doublings;
  sap_pkg::status_e            status;

  sap_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .stat_i      (dp_stat),
    .cmd_o       (cmd)
  );

  sap_dp #(
    .INITIAL_ATLAS_LOG (INITIAL_ATLAS_LOG),
    .MAX_ATLAS_LOG     (MAX_ATLAS_LOG),
    .MAX_SHELVES       (MAX_SHELVES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .glyph_width_i    (s_axis_tdata[9:0]),
    .glyph_height_i   (s_axis_tdata[19:10]),
    .shelf_height_i   (s_axis_tdata[29:20]),
    .cmd_i            (cmd),
    .stat_o           (dp_stat),
    .out_ready_i      (m_axis_tready),
    .out_valid_o      (m_axis_tvalid),
    .rect_left_o      (rect_left),
    .rect_bottom_o    (rect_bottom),
    .rect_right_o     (rect_right),
    .rect_top_o       (rect_top),
    .atlas_size_log_o (atlas_size_log),
    .doublings_o      (doublings),
    .status_o         (status)
  );

  // Pack the result transaction
  assign m_axis_tdata = {6'd0, status, doublings, atlas_size_log, rect_top,
                         rect_right, rect_bottom, rect_left};

endmodule

`default_nettype wire

### sv/sap_checker.sv
// ----------------------------------------------------------------------------
// sap_checker
// Port-level checks of the shelf atlas packer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sap_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic [sap_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [sap_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

  // Take no second request while one is being searched
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted during a search");

  // Report a failure with an empty rectangle and no doublings
  a_fail_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[57:56] != 2'd0) |->
      (m_axis_tdata[48:0] == '0) && (m_axis_tdata[55:53] == '0))
    else $error("failed placement carries a rectangle");

  // Use only defined status codes and zero padding
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[57:56] != 2'd3) && (m_axis_tdata[63:58] == '0))
    else $error("undefined status or nonzero padding");

endmodule

bind shelf_atlas_packer sap_checker u_sap_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

### tb/shelf_atlas_packer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shelf_atlas_packer_test
// Self-checking stream testbench for the shelf atlas packer. A short directed
// run hits zero sizes, the widest glyph, the exact-fit width boundary and a
// double atlas doubling. Random glyph requests then run in four traffic
// phases: no idling, sender idle, receiver stalling, and both. A closing run
// of tall and wide requests drives the packer into a full shelf table and the
// maximum atlas size. A scoreboard keeps its own copy of the shelf table,
// predicts every placement and compares each result field by field.
// ----------------------------------------------------------------------------

module shelf_atlas_packer_test;

  localparam int unsigned DIM_W            = sap_pkg::DIM_W;
  localparam int unsigned COORD_W          = sap_pkg::COORD_W;
  localparam int unsigned TOP_W            = sap_pkg::TOP_W;
  localparam int unsigned LOG_W            = sap_pkg::LOG_W;
  localparam int unsigned DBL_W            = sap_pkg::DBL_W;
  localparam int unsigned IN_TDATA_W       = sap_pkg::IN_TDATA_W;
  localparam int unsigned OUT_TDATA_W      = sap_pkg::OUT_TDATA_W;
  localparam int unsigned INIT_LOG         = sap_pkg::INITIAL_ATLAS_LOG_DEF;
  localparam int unsigned MAX_LOG          = sap_pkg::MAX_ATLAS_LOG_DEF;
  localparam int unsigned MAX_SHELVES      = sap_pkg::MAX_SHELVES_DEF;
  localparam int unsigned DIM_MAX          = (1 << DIM_W) - 1;
  // Highest shelf position at or below which a maximum-height shelf still fits
  localparam int unsigned TALL_ROOM        = (1 << MAX_LOG) - DIM_MAX;
  localparam int unsigned RANDOM_PER_PHASE = 475;
  localparam int unsigned CLOSING_LIMIT    = 400;
  localparam int unsigned DRAIN_CYCLES     = 400;
  localparam int unsigned WATCHDOG_LIMIT   = 4000;
  localparam int unsigned REPORT_LIMIT     = 10;

  // Result fields, lowest bits last so a cast from tdata unpacks them
  typedef struct packed {
    logic [OUT_TDATA_W-58-1:0] pad;
    sap_pkg::status_e          status;
    logic [DBL_W-1:0]          doublings;
    logic [LOG_W-1:0]          size_log;
    logic [TOP_W-1:0]          rect_top;
    logic [COORD_W-1:0]        rect_right;
    logic [COORD_W-1:0]        rect_bottom;
    logic [COORD_W-1:0]        rect_left;
  } placement_t;

  // Shelf table copy, placement prediction and result checking
  class placement_board;
    int unsigned shelf_height_tab [MAX_SHELVES];
    int unsigned shelf_pos_tab [MAX_SHELVES];
    int unsigned shelf_len_tab [MAX_SHELVES];
    int unsigned shelf_count;
    int unsigned next_shelf_pos;
    int unsigned atlas_log;
    placement_t  pending_placements [$];
    int unsigned errors;
    bit          seen_shelf_full;
    bit          seen_atlas_max;

    function new();
      shelf_count     = 0;
      next_shelf_pos  = 0;
      atlas_log       = INIT_LOG;
      errors          = 0;
      seen_shelf_full = 1'b0;
      seen_atlas_max  = 1'b0;
    endfunction

    // Place one accepted glyph request and queue the result it must produce
    function void place_glyph(int unsigned w, int unsigned h, int unsigned sh);
      int unsigned      trial_log;
      int unsigned      grown;
      int unsigned      slot;
      int unsigned      side;
      int unsigned      left;
      bit               found;
      sap_pkg::status_e outcome;
      placement_t       p;
      trial_log = atlas_log;
      grown     = 0;
      slot      = 0;
      found     = 1'b0;
      outcome   = sap_pkg::ST_PLACED;
      // First fit over the shelves, then a new shelf, then a larger atlas
      while (!found && outcome == sap_pkg::ST_PLACED) begin
        side = 1 << trial_log;
        for (int unsigned i = 0; i < shelf_count; i++) begin
          if (!found && shelf_height_tab[i] >= sh && shelf_len_tab[i] + w < side) begin
            slot  = i;
            found = 1'b1;
          end
        end
        if (!found) begin
          if (next_shelf_pos + sh <= side) begin
            if (shelf_count >= MAX_SHELVES) begin
              outcome = sap_pkg::ST_SHELF_FULL;
            end else begin
              slot                   = shelf_count;
              shelf_height_tab[slot] = sh;
              shelf_pos_tab[slot]    = next_shelf_pos;
              shelf_len_tab[slot]    = 0;
              shelf_count++;
              next_shelf_pos += sh;
              found = 1'b1;
            end
          end else if (trial_log >= MAX_LOG) begin
            outcome = sap_pkg::ST_ATLAS_MAX;
          end else begin
            trial_log++;
            grown++;
          end
        end
      end
      // Commit only on success; a failure leaves the table and atlas as they were
      p = '0;
      if (outcome == sap_pkg::ST_PLACED) begin
        atlas_log           = trial_log;
        left                = shelf_len_tab[slot];
        shelf_len_tab[slot] = left + w;
        p.rect_left         = COORD_W'(left);
        p.rect_bottom       = COORD_W'(shelf_pos_tab[slot]);
        p.rect_right        = COORD_W'(left + w);
        p.rect_top          = TOP_W'(shelf_pos_tab[slot] + h);
        p.doublings         = DBL_W'(grown);
      end
      p.size_log = LOG_W'(atlas_log);
      p.status   = outcome;
      if (outcome == sap_pkg::ST_SHELF_FULL) seen_shelf_full = 1'b1;
      if (outcome == sap_pkg::ST_ATLAS_MAX) seen_atlas_max = 1'b1;
      pending_placements.push_back(p);
    endfunction

    function string describe(placement_t p);
      return $sformatf("left %0d bottom %0d right %0d top %0d log %0d dbl %0d status %0d pad %0d",
                       p.rect_left, p.rect_bottom, p.rect_right, p.rect_top,
                       p.size_log, p.doublings, p.status, p.pad);
    endfunction

    // Compare one accepted result with the oldest pending placement
    function void check_placement(logic [OUT_TDATA_W-1:0] tdata);
      placement_t got;
      placement_t want;
      got = placement_t'(tdata);
      if (pending_placements.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT) $display("unrequested placement: %s", describe(got));
        return;
      end
      want = pending_placements.pop_front();
      if (got.rect_left !== want.rect_left || got.rect_bottom !== want.rect_bottom ||
          got.rect_right !== want.rect_right || got.rect_top !== want.rect_top ||
          got.size_log !== want.size_log || got.doublings !== want.doublings ||
          got.status !== want.status || got.pad !== want.pad) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("placement mismatch: expected %s", describe(want));
          $display("                    actual   %s", describe(got));
        end
      end
    endfunction
  endclass

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  placement_board board = new();
  int unsigned    send_idle_pct = 0;
  int unsigned    stall_pct     = 0;
  int unsigned    quiet_cycles  = 0;

  shelf_atlas_packer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Check results as they are accepted, then pick the next ready level
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_placement(m_axis_tdata);
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Abort when no transaction moves on either side for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Offer one glyph request, idling first at the current rate
  task automatic send_glyph(input int unsigned w, input int unsigned h, input int unsigned sh);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W - 3 * DIM_W){1'b0}}, sh[DIM_W-1:0], h[DIM_W-1:0],
                      w[DIM_W-1:0]};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.place_glyph(w, h, sh);
  endtask

  // Hold the sender until every pending placement has come back
  task automatic wait_for_placements();
    s_axis_tvalid <= 1'b0;
    while (board.pending_placements.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned w;
    int unsigned h;
    int unsigned sh;
    int unsigned roll;
    int unsigned closing_n;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: smallest, zero sizes, widest glyph, exact-fit width, two doublings
    send_glyph(1, 1, 1);
    send_glyph(0, 0, 0);
    send_glyph(DIM_MAX, DIM_MAX, 1);
    send_glyph(DIM_MAX, 0, 1);
    send_glyph(255, 5, 1);
    send_glyph(254, 5, 1);
    send_glyph(7, DIM_MAX, 600);
    send_glyph(512, 512, 512);
    send_glyph(341, 682, 341);
    send_glyph(682, 341, 40);
    send_glyph(1, DIM_MAX, 0);
    send_glyph(0, 1, 8);
    wait_for_placements();

    // Random requests over four traffic phases
    for (int unsigned ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 53;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 53;
        end
        default: begin
          send_idle_pct = 31;
          stall_pct     = 31;
        end
      endcase
      for (int unsigned n = 0; n < RANDOM_PER_PHASE; n++) begin
        h    = $urandom_range(DIM_MAX);
        roll = $urandom_range(99);
        // Late in the table, push tall shelves so the atlas can run out of height
        if (board.shelf_count >= 40 && !board.seen_atlas_max &&
            board.next_shelf_pos <= TALL_ROOM && roll < 50) begin
          w  = $urandom_range(DIM_MAX, 700);
          sh = $urandom_range(DIM_MAX, 900);
        end else begin
          roll = $urandom_range(99);
          if (roll < 70) w = $urandom_range(48, 1);
          else if (roll < 85) w = $urandom_range(DIM_MAX);
          else if (roll < 95) w = $urandom_range(255);
          else w = 0;
          roll = $urandom_range(99);
          if (roll < 50) sh = 4 << $urandom_range(4);
          else if (roll < 85) sh = $urandom_range(96, 1);
          else if (roll < 97) sh = $urandom_range(400, 97);
          else sh = $urandom_range(DIM_MAX);
        end
        send_glyph(w, h, sh);
      end
      wait_for_placements();
    end

    // Closing: tall and wide requests until the table and the atlas give out
    closing_n = 0;
    while (!(board.seen_shelf_full && board.seen_atlas_max) && closing_n < CLOSING_LIMIT) begin
      sh = (closing_n % 2 == 0) ? DIM_MAX : 1;
      send_glyph(DIM_MAX, $urandom_range(DIM_MAX), sh);
      closing_n++;
    end

    wait_for_placements();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0 && board.pending_placements.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
sv/sap_pkg.sv
sv/sap_ctrl.sv
sv/sap_dp.sv
sv/shelf_atlas_packer.sv
sv/sap_checker.sv
tb/shelf_atlas_packer_test.sv
